>>> hdl/serial_memory_access_slave_unit_macros.svh
// ----------------------------------------------------------------------------
// Serial memory access slave: assertion macros
// Shared property forms for the block's checks; clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_MEMORY_ACCESS_SLAVE_UNIT_MACROS_SVH
`define SERIAL_MEMORY_ACCESS_SLAVE_UNIT_MACROS_SVH

// same-cycle implication
`define SMAS_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/smas_pkg.sv
// ----------------------------------------------------------------------------
// smas_pkg
// Types and constants shared by the serial memory access slave modules.
// ----------------------------------------------------------------------------
package smas_pkg;

	localparam int MEM_BYTES_DEF = 1024;

	// offset = 15-bit word index times four
	localparam int OFF_W = 17;
	// second operand of the address unit: payload length, position or count
	localparam int ADD_W = 16;
	// sum width, holds any offset plus addend
	localparam int SUM_W = 18;

	localparam int POS_W = 12;
	localparam int LIM_W = 7;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MALFORMED = 2'd1;
	localparam logic [1:0] ST_OVERRUN   = 2'd2;

	localparam logic [LIM_W-1:0] REPLY_CAP       = 7'd64;
	localparam logic [LIM_W-1:0] REPLY_LIMIT_RST = 7'd32;

	typedef struct packed {
		logic [SUM_W-1:0] sum;   // offset plus addend
		logic             over;  // sum passes the end of memory
	} smas_sum_t;

endpackage

>>> hdl/smas_ram.sv
// ----------------------------------------------------------------------------
// smas_ram
// Byte memory, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smas_ram #(
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/smas_addr_unit.sv
// ----------------------------------------------------------------------------
// smas_addr_unit
// Shared address adder and end-of-memory compare.
// ----------------------------------------------------------------------------
module smas_addr_unit import smas_pkg::*; #(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic [OFF_W-1:0] off,
	input  logic [ADD_W-1:0] addend,
	output smas_sum_t        res
);

	localparam logic [SUM_W-1:0] MEM_END = SUM_W'(MEM_BYTES);

	logic [SUM_W-1:0] sum;

	assign sum      = SUM_W'(off) + SUM_W'(addend);
	assign res.sum  = sum;
	assign res.over = (sum > MEM_END);

endmodule

>>> hdl/serial_memory_access_slave_unit.sv
// ----------------------------------------------------------------------------
// serial_memory_access_slave_unit
// Byte-serial memory access slave: index word, write payload or read request.
// ----------------------------------------------------------------------------
// Reset: a clearing pass zeroes every byte of the memory, one byte a cycle;
//   no input beat is taken meanwhile (config writes are).
// Input beats other than a message's last are taken without a stall.
// Unless a read burst follows, a status beat is offered the cycle after the last input beat of a message.
// Read replies: each data beat goes through address, memory read on the single read port and output, in turn,
//   and the next is not begun until it is taken; no input is taken until the last beat goes.
module serial_memory_access_slave_unit import smas_pkg::*; #(
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// input beats
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       data_byte,
	input  logic [POS_W-1:0] msg_len,
	// result beats
	output logic             out_valid,
	input  logic             out_stall,
	output logic [1:0]       status,
	output logic [7:0]       reply_byte,
	output logic             byte_valid,
	output logic             last,
	// reply limit register
	input  logic             cfg_we,
	input  logic [LIM_W-1:0] cfg_wdata
);

	`include "serial_memory_access_slave_unit_macros.svh"

	localparam int AW = $clog2(MEM_BYTES);
	localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

	// sequencer states
	localparam logic [2:0] S_CLEAR = 3'd0;  // zeroing the memory after reset
	localparam logic [2:0] S_IDLE  = 3'd1;  // taking message bytes
	localparam logic [2:0] S_ISSUE = 3'd2;  // read address out to memory
	localparam logic [2:0] S_FETCH = 3'd3;  // read data back, load output
	localparam logic [2:0] S_HOLD  = 3'd4;  // output beat waiting to be taken

	logic [2:0]       state_q;
	logic [AW-1:0]    clr_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] len_q;
	logic [7:0]       idx_lo_q;
	logic [7:0]       idx_hi_q;
	logic [7:0]       cnt_lo_q;
	logic [1:0]       err_q;
	logic [LIM_W-1:0] max_reply_q;
	logic [LIM_W-1:0] rd_idx_q;
	logic [LIM_W-1:0] rd_cnt_q;

	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [7:0]       reply_q;
	logic             bvalid_q;
	logic             last_q;

	logic             in_acc;
	logic             out_take;
	logic [POS_W-1:0] len_eff;
	logic             is_last;
	logic             short_msg;
	logic             rd_msg;
	logic [OFF_W-1:0] off_cur;
	logic [ADD_W-1:0] addend;
	smas_sum_t        au;
	logic [ADD_W-1:0] rd_count;
	logic [LIM_W-1:0] limit;
	logic             rd_refused;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [7:0]       ram_wdata;
	logic             ram_re;
	logic [7:0]       ram_rdata;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_take = out_valid_q && !out_stall;

	// length is sampled on the first byte; zero counts as one
	always_comb begin
		if (pos_q == '0) begin
			len_eff = (msg_len == '0) ? POS_W'(1) : msg_len;
		end else begin
			len_eff = len_q;
		end
	end

	assign is_last   = ({1'b0, pos_q} + (POS_W+1)'(1)) >= {1'b0, len_eff};
	assign short_msg = (len_eff <= POS_W'(2));
	assign rd_msg    = (pos_q == POS_W'(1)) ? data_byte[7] : idx_hi_q[7];

	// the index word's high byte is still on the bus at position one
	always_comb begin
		if (pos_q == POS_W'(1)) begin
			off_cur = {data_byte[6:0], idx_lo_q, 2'b00};
		end else begin
			off_cur = {idx_hi_q[6:0], idx_lo_q, 2'b00};
		end
	end

	assign rd_count = {data_byte, cnt_lo_q};

	// second operand of the shared adder, chosen by what this cycle needs
	always_comb begin
		if (state_q != S_IDLE) begin
			addend = ADD_W'(rd_idx_q);                   // burst address
		end else if (pos_q == POS_W'(1)) begin
			addend = ADD_W'(len_eff - POS_W'(2));        // write payload end
		end else if (rd_msg) begin
			addend = rd_count;                           // read range end
		end else begin
			addend = ADD_W'(pos_q - POS_W'(2));          // write address
		end
	end

	smas_addr_unit #(
		.MEM_BYTES (MEM_BYTES)
	) u_addr (
		.off    (off_cur),
		.addend (addend),
		.res    (au)
	);

	assign limit      = (max_reply_q > REPLY_CAP) ? REPLY_CAP : max_reply_q;
	assign rd_refused = (rd_count > ADD_W'(limit)) || au.over;

	// memory ports: clearing pass, write payload, burst reads
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = au.sum[AW-1:0];
		ram_wdata = data_byte;
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = 8'h00;
		end else if (in_acc && (pos_q >= POS_W'(2)) && !idx_hi_q[7] && (err_q == ST_OK)) begin
			ram_we = 1'b1;
		end
	end

	assign ram_re = (state_q == S_ISSUE);

	smas_ram #(
		.DEPTH (MEM_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (au.sum[AW-1:0]),
		.rdata (ram_rdata)
	);

	// reply limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_reply_q <= REPLY_LIMIT_RST;
		end else if (cfg_we) begin
			max_reply_q <= cfg_wdata;
		end
	end

	// message parsing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			len_q    <= '0;
			idx_lo_q <= '0;
			idx_hi_q <= '0;
			cnt_lo_q <= '0;
			err_q    <= ST_OK;
		end else if (in_acc) begin
			pos_q <= is_last ? '0 : pos_q + POS_W'(1);
			if (pos_q == '0) begin
				len_q    <= len_eff;
				idx_lo_q <= data_byte;
			end else if (pos_q == POS_W'(1)) begin
				idx_hi_q <= data_byte;
				if (short_msg) begin
					err_q <= ST_MALFORMED;
				end else if (data_byte[7]) begin
					err_q <= (len_eff == POS_W'(4)) ? ST_OK : ST_MALFORMED;
				end else begin
					err_q <= au.over ? ST_OVERRUN : ST_OK;
				end
			end else if ((pos_q == POS_W'(2)) && idx_hi_q[7]) begin
				cnt_lo_q <= data_byte;
			end
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rd_idx_q    <= '0;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc && is_last) begin
						if (short_msg || (err_q != ST_OK)
								|| !rd_msg || rd_refused || (rd_count == '0)) begin
							out_valid_q <= 1'b1;
							state_q     <= S_HOLD;
						end else begin
							rd_idx_q <= '0;
							rd_cnt_q <= rd_count[LIM_W-1:0];
							state_q  <= S_ISSUE;
						end
					end
				end
				S_ISSUE: begin
					state_q <= S_FETCH;
				end
				S_FETCH: begin
					out_valid_q <= 1'b1;
					state_q     <= S_HOLD;
				end
				S_HOLD: begin
					if (out_take) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							state_q <= S_IDLE;
						end else begin
							rd_idx_q <= rd_idx_q + LIM_W'(1);
							state_q  <= S_ISSUE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_acc && is_last) begin
			reply_q  <= 8'h00;
			bvalid_q <= 1'b0;
			last_q   <= 1'b1;
			if (short_msg) begin
				status_q <= ST_MALFORMED;
			end else if (err_q != ST_OK) begin
				status_q <= err_q;
			end else if (rd_msg && rd_refused) begin
				status_q <= ST_OVERRUN;
			end else begin
				status_q <= ST_OK;
			end
		end else if (state_q == S_FETCH) begin
			status_q <= ST_OK;
			reply_q  <= ram_rdata;
			bvalid_q <= 1'b1;
			last_q   <= ((rd_idx_q + LIM_W'(1)) == rd_cnt_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign reply_byte = reply_q;
	assign byte_valid = bvalid_q;
	assign last       = last_q;

	`SMAS_ASSERT_HOLDS(a_out_blocks_in, out_valid_q, in_stall, "input taken while a beat waits")
	`SMAS_ASSERT_NEXT(a_last_stalls, in_acc && is_last, in_stall, "no response after last byte")
	`SMAS_ASSERT_HOLDS(a_burst_bound, state_q == S_FETCH, rd_idx_q < rd_cnt_q, "burst past count")
	`SMAS_ASSERT_HOLDS(a_we_state, ram_we, (state_q == S_CLEAR) || (state_q == S_IDLE), "stray write")

endmodule
